// File: hw/rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mhpq_pkg
// Shared constants, status codes and the sequencer microprogram of the
// max-heap priority queue.
// ============================================================================
package mhpq_pkg;

   // default sizes
   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_KEY_WIDTH = 32;
   localparam int DEF_TAG_WIDTH = 16;

   // request kind carried in tuser
   localparam logic ACT_EXTRACT = 1'b1;

   // result status carried in tuser
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_LOADED    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXTRACTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // microprogram step addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] ST_LOAD     = 4'd1;
   localparam logic [STEP_W-1:0] ST_EMIT_L   = 4'd2;
   localparam logic [STEP_W-1:0] ST_BUILD    = 4'd3;
   localparam logic [STEP_W-1:0] ST_PAR      = 4'd4;
   localparam logic [STEP_W-1:0] ST_LEFT     = 4'd5;
   localparam logic [STEP_W-1:0] ST_DECIDE   = 4'd6;
   localparam logic [STEP_W-1:0] ST_FILL     = 4'd7;
   localparam logic [STEP_W-1:0] ST_END      = 4'd8;
   localparam logic [STEP_W-1:0] ST_EXT      = 4'd9;
   localparam logic [STEP_W-1:0] ST_EXT_LAST = 4'd10;
   localparam logic [STEP_W-1:0] ST_EMIT_X   = 4'd11;
   localparam logic [STEP_W-1:0] ST_EMIT_E   = 4'd12;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
   localparam logic [OP_W-1:0] OP_BUILD    = 4'd2;
   localparam logic [OP_W-1:0] OP_PAR      = 4'd3;
   localparam logic [OP_W-1:0] OP_LEFT     = 4'd4;
   localparam logic [OP_W-1:0] OP_DECIDE   = 4'd5;
   localparam logic [OP_W-1:0] OP_FILL     = 4'd6;
   localparam logic [OP_W-1:0] OP_RETURN   = 4'd7;
   localparam logic [OP_W-1:0] OP_EXT      = 4'd8;
   localparam logic [OP_W-1:0] OP_EXT_LAST = 4'd9;
   localparam logic [OP_W-1:0] OP_ROOT     = 4'd10;

   // sequencer jump kinds
   localparam int JMP_W = 3;
   localparam logic [JMP_W-1:0] J_NEXT      = 3'd0;  // step + 1
   localparam logic [JMP_W-1:0] J_ACCEPT    = 3'd1;  // wait for beat, extract to target
   localparam logic [JMP_W-1:0] J_EMIT      = 3'd2;  // wait for output slot, then target
   localparam logic [JMP_W-1:0] J_EMIT_LAST = 3'd3;  // wait for slot, last to target else idle
   localparam logic [JMP_W-1:0] J_BRANCH    = 3'd4;  // flag to target else step + 1
   localparam logic [JMP_W-1:0] J_LOOP      = 3'd5;  // flag to target else idle

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [JMP_W-1:0]  jmp;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         ST_IDLE:     w = '{OP_NONE,     J_ACCEPT,    ST_EXT};
         ST_LOAD:     w = '{OP_LOAD,     J_NEXT,      ST_IDLE};
         ST_EMIT_L:   w = '{OP_NONE,     J_EMIT_LAST, ST_BUILD};
         ST_BUILD:    w = '{OP_BUILD,    J_NEXT,      ST_IDLE};
         ST_PAR:      w = '{OP_PAR,      J_NEXT,      ST_IDLE};
         ST_LEFT:     w = '{OP_LEFT,     J_BRANCH,    ST_FILL};
         ST_DECIDE:   w = '{OP_DECIDE,   J_BRANCH,    ST_LEFT};
         ST_FILL:     w = '{OP_FILL,     J_NEXT,      ST_IDLE};
         ST_END:      w = '{OP_RETURN,   J_LOOP,      ST_PAR};
         ST_EXT:      w = '{OP_EXT,      J_BRANCH,    ST_EMIT_E};
         ST_EXT_LAST: w = '{OP_EXT_LAST, J_NEXT,      ST_IDLE};
         ST_EMIT_X:   w = '{OP_ROOT,     J_EMIT,      ST_PAR};
         ST_EMIT_E:   w = '{OP_NONE,     J_EMIT,      ST_IDLE};
         default:     w = '{OP_NONE,     J_LOOP,      ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// max_heap_priority_queue
// Binary max-heap of signed keys with tags, run by a microcoded sequencer
// over a one-read, one-write entry memory.
// ============================================================================
// Usage:
//   req channel: one beat per command. tuser = 1 extracts the maximum,
//   tuser = 0 loads tdata (key, tag) at the end of the array; a load with
//   tlast set then rebuilds the heap over all held entries.
//   rsp channel: exactly one beat per command, status in tuser, removed
//   key and tag in tdata (zero unless status is extracted).
// Timing:
//   one command at a time. An extract moves the last entry to the root and
//   sinks it; a load with tlast then sifts each index from count/2 down
//   to 0. Sifting speed is set by the single read port of the entry
//   memory: one child is fetched per cycle and every level needs both
//   children.
// Reset clears the count and the sequencer; entry memory is not cleared.
// A stalled result waits in the output register while the next command is
// accepted; that command's result waits in its emit step until the slot
// frees.
// ============================================================================
module max_heap_priority_queue #(
   parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
   parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // key, tag, zero pad
   input  logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0]      req_tdata,
   // action
   input  logic                                          req_tuser,
   input  logic                                          req_tlast,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // out_key, out_tag, zero pad
   output logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   // status
   output logic [mhpq_pkg::STATUS_W-1:0]                 rsp_tuser
);
   import mhpq_pkg::*;

   localparam int IW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = IW + 2;
   localparam int EW    = KEY_WIDTH + TAG_WIDTH;
   localparam int DW    = ((EW + 7) / 8) * 8;

   // signed order on the key part of two entries
   function automatic logic key_gt(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic signed [KEY_WIDTH-1:0] ka;
      logic signed [KEY_WIDTH-1:0] kb;
      ka = a[EW-1 -: KEY_WIDTH];
      kb = b[EW-1 -: KEY_WIDTH];
      return ka > kb;
   endfunction

   // entry memory, key in the upper bits
   logic [EW-1:0] mem [CAPACITY];

   logic [STEP_W-1:0]   pc_ff, pc_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                build_ff, build_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [IW-1:0]       k_ff, k_in;
   logic [EW-1:0]       par_ff, par_in;
   logic [EW-1:0]       best_ff, best_in;
   logic [IW-1:0]       best_idx_ff, best_idx_in;
   logic [EW-1:0]       rdata_ff;
   logic [KEY_WIDTH-1:0] item_key_ff;
   logic [TAG_WIDTH-1:0] item_tag_ff;
   logic                item_last_ff;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [KEY_WIDTH-1:0] res_key_ff, res_key_in;
   logic [TAG_WIDTH-1:0] res_tag_ff, res_tag_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [KEY_WIDTH-1:0] rsp_key_ff;
   logic [TAG_WIDTH-1:0] rsp_tag_ff;

   ucode_type           word;
   logic                accept;
   logic                slot_free;
   logic                emit;
   logic                flag;
   logic                rd_en, wr_en;
   logic [IW-1:0]       rd_addr, wr_addr;
   logic [EW-1:0]       wr_data;
   logic [CW-1:0]       left_c, right_c, cnt_c, win_left;
   logic                left_ok, right_ok, take_left, take_right;
   logic [EW-1:0]       win_entry;
   logic [IW-1:0]       win_idx;
   logic [CNT_W-1:0]    cnt_m1, half;
   logic [IW-1:0]       k_m1;

   // control word of the current step
   assign word       = ucode_rom(pc_ff);
   assign req_tready = (pc_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit       = slot_free && ((word.jmp == J_EMIT) || (word.jmp == J_EMIT_LAST));

   // child indices and compares
   assign left_c     = {1'b0, pos_ff, 1'b1};
   assign right_c    = left_c + CW'(1);
   assign cnt_c      = CW'(cnt_ff);
   assign left_ok    = left_c < cnt_c;
   assign right_ok   = right_c < cnt_c;
   assign take_left  = key_gt(rdata_ff, par_ff);
   assign take_right = right_ok && key_gt(rdata_ff, best_ff);
   assign win_entry  = take_right ? rdata_ff : best_ff;
   assign win_idx    = take_right ? right_c[IW-1:0] : best_idx_ff;
   assign win_left   = {1'b0, win_idx, 1'b1};
   assign cnt_m1     = cnt_ff - CNT_W'(1);
   assign half       = cnt_ff >> 1;
   assign k_m1       = k_ff - IW'(1);

   // datapath decode
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      flag          = 1'b0;
      pos_in        = pos_ff;
      k_in          = k_ff;
      par_in        = par_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      cnt_in        = cnt_ff;
      build_in      = build_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;
      case (word.op)
         OP_LOAD: begin
            res_key_in = '0;
            res_tag_in = '0;
            if (cnt_ff == CNT_W'(CAPACITY)) begin
               res_status_in = STATUS_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = cnt_ff[IW-1:0];
               wr_data       = {item_key_ff, item_tag_ff};
               cnt_in        = cnt_ff + CNT_W'(1);
               res_status_in = STATUS_LOADED;
            end
         end
         OP_BUILD: begin
            k_in     = half[IW-1:0];
            pos_in   = half[IW-1:0];
            build_in = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = half[IW-1:0];
         end
         OP_PAR: begin
            par_in  = rdata_ff;
            rd_en   = 1'b1;
            rd_addr = left_c[IW-1:0];
         end
         // left child is in rdata; fetch the right one
         OP_LEFT: begin
            flag        = !left_ok;
            best_in     = take_left ? rdata_ff : par_ff;
            best_idx_in = take_left ? left_c[IW-1:0] : pos_ff;
            rd_en       = 1'b1;
            rd_addr     = right_c[IW-1:0];
         end
         // right child is in rdata; move the winner up and descend
         OP_DECIDE: begin
            flag = (win_idx != pos_ff);
            if (flag) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = win_entry;
               pos_in  = win_idx;
               rd_en   = 1'b1;
               rd_addr = win_left[IW-1:0];
            end
         end
         OP_FILL: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = par_ff;
         end
         OP_RETURN: begin
            flag = build_ff && (k_ff != '0);
            if (flag) begin
               k_in    = k_m1;
               pos_in  = k_m1;
               rd_en   = 1'b1;
               rd_addr = k_m1;
            end else begin
               build_in = 1'b0;
            end
         end
         OP_EXT: begin
            flag = (cnt_ff == '0);
            if (flag) begin
               res_status_in = STATUS_EMPTY;
               res_key_in    = '0;
               res_tag_in    = '0;
            end else begin
               rd_en   = 1'b1;
               rd_addr = '0;
            end
         end
         // root is in rdata; fetch the last entry
         OP_EXT_LAST: begin
            res_status_in = STATUS_EXTRACTED;
            res_key_in    = rdata_ff[EW-1 -: KEY_WIDTH];
            res_tag_in    = rdata_ff[TAG_WIDTH-1:0];
            rd_en         = 1'b1;
            rd_addr       = cnt_m1[IW-1:0];
            cnt_in        = cnt_m1;
         end
         OP_ROOT: begin
            pos_in = '0;
         end
         default: begin
         end
      endcase
   end

   // step sequencing
   always_comb begin
      pc_in = pc_ff;
      case (word.jmp)
         J_NEXT: pc_in = pc_ff + STEP_W'(1);
         J_ACCEPT: begin
            if (accept) begin
               pc_in = (req_tuser == ACT_EXTRACT) ? word.target : pc_ff + STEP_W'(1);
            end
         end
         J_EMIT: begin
            if (slot_free) begin
               pc_in = word.target;
            end
         end
         J_EMIT_LAST: begin
            if (slot_free) begin
               pc_in = item_last_ff ? word.target : ST_IDLE;
            end
         end
         J_BRANCH: pc_in = flag ? word.target : pc_ff + STEP_W'(1);
         J_LOOP:   pc_in = flag ? word.target : ST_IDLE;
         default:  pc_in = ST_IDLE;
      endcase
   end

   // output register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_IDLE;
         cnt_ff       <= '0;
         build_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         build_ff     <= build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      par_ff        <= par_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      if (accept) begin
         item_key_ff  <= req_tdata[KEY_WIDTH-1:0];
         item_tag_ff  <= req_tdata[EW-1:KEY_WIDTH];
         item_last_ff <= req_tlast;
      end
      if (emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_tag_ff    <= res_tag_ff;
      end
   end

   // entry memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = DW'({rsp_tag_ff, rsp_key_ff});

endmodule

// File: hw/rtl/mhpq_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mhpq_checker
// Port-level assertions for the max-heap priority queue, bound to the top.
// ============================================================================
module mhpq_checker #(
   parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
   parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_tvalid,
   input logic                                     req_tready,
   // key, tag, zero pad
   input logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0] req_tdata,
   // action
   input logic                                     req_tuser,
   input logic                                     req_tlast,
   input logic                                     rsp_tvalid,
   input logic                                     rsp_tready,
   // out_key, out_tag, zero pad
   input logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // status
   input logic [mhpq_pkg::STATUS_W-1:0]            rsp_tuser
);
   import mhpq_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // commands accepted whose result is not yet delivered
   always_comb begin
      pend_in = pend_ff + 2'(req_beat) - 2'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one command in the sequencer at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("request taken while a command runs");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // every result belongs to an accepted command
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("result without a command");

   // at most one running command plus one waiting result
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many commands outstanding");

   // request fields are not checked here
   logic unused_req;
   assign unused_req = ^{req_tdata, req_tuser, req_tlast, STATUS_W[0]};

endmodule

bind max_heap_priority_queue mhpq_checker #(
   .KEY_WIDTH (KEY_WIDTH),
   .TAG_WIDTH (TAG_WIDTH)
) u_mhpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
